@@ src/cvl_pkg.sv @@
// ---------------------------------------------------------------------------
// Chord voice leader package
// Shared constants and pitch-class helpers.
// ---------------------------------------------------------------------------
package cvl_pkg;

    localparam int NOTES_DEF = 4;
    localparam int NOTE_W    = 7;
    localparam int PC_N      = 12;
    // floor(n / 12) equals (n * 43) >> 9 for every 7-bit n.
    localparam int PC_RECIP  = 43;
    localparam int PC_SHIFT  = 9;

    // Pitch class of a 7-bit MIDI note, by reciprocal multiplication.
    function automatic logic [3:0] pc_of(input logic [6:0] n);
        logic [12:0] p;
        logic [3:0]  q;
        logic [6:0]  r;
        p = 13'(n) * 13'(PC_RECIP);
        q = p[PC_SHIFT +: 4];
        r = n - 7'(q) * 7'(PC_N);
        return r[3:0];
    endfunction

    // Signed shortest step from pitch class a to pitch class b, tritone up.
    function automatic logic signed [3:0] pc_step(input logic [3:0] a,
                                                  input logic [3:0] b);
        logic [4:0] fwd;
        fwd = 5'(b) + 5'(PC_N) - 5'(a);
        if (fwd >= 5'(PC_N)) fwd = fwd - 5'(PC_N);
        if (fwd <= 5'd6) return 4'(signed'(fwd));
        return 4'(signed'(fwd)) - 4'sd12;
    endfunction

    function automatic logic [2:0] pc_abs(input logic [3:0] a, input logic [3:0] b);
        logic signed [3:0] d;
        d = pc_step(a, b);
        return d[3] ? 3'(-d) : 3'(d);
    endfunction

endpackage

@@ src/chord_voice_leader.sv @@
// ---------------------------------------------------------------------------
// Chord voice leader
// Leads the held chord to each new chord by stable matching of notes.
// ---------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         tdata: note_0..note_{N-1}; tuser: note_on
// m_axis    out        tdata: prev notes, prev_valid, led notes, led_valid
//
// A note-off goes straight to the output state; a first note-on leads its
// voices directly. A later note-on runs a ranking pass that scores one (self,
// other, compared) triple per cycle, an init step, up to N*N + N proposal
// steps, one proposal step per cycle, and then leads one voice per cycle.
// i_rst_n is synchronous and clears the held chord and the sequencer.
// The input is not ready while an item is in work; a finished result waits in
// the output register, so the next request is taken while it is unread.
// ---------------------------------------------------------------------------
module chord_voice_leader #(
    parameter int NOTES = cvl_pkg::NOTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // note_0 .. note_{NOTES-1}, zero pad to bytes
    input  logic [((NOTES*7+7)/8)*8-1:0]  s_axis_tdata,
    // note_on
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // prev_note_0..N-1, prev_valid, led_note_0..N-1, led_valid, zero pad
    output logic [((NOTES*14+2+7)/8)*8-1:0] m_axis_tdata
);
    localparam int IW = $clog2(NOTES) > 0 ? $clog2(NOTES) : 1;
    localparam int PW = IW + 1;
    localparam int GW = $clog2(NOTES*NOTES + NOTES + 1) + 1;
    localparam int OW = ((NOTES*14+2+7)/8)*8;

    typedef enum logic [2:0] {
        S_IDLE, S_RANK, S_INIT, S_PROP, S_LEAD, S_OUT
    } t_state;

    t_state             r_state;
    logic [6:0]         r_held  [NOTES];
    logic [6:0]         r_fresh [NOTES];
    logic               r_have;
    logic               r_on;
    // Rank tables: pref[p][k] is held note at place k for fresh note p;
    // arank[a][f] is the place of fresh note f in held note a's list.
    logic [IW-1:0]      r_pref  [NOTES][NOTES];
    logic [IW-1:0]      r_arank [NOTES][NOTES];
    logic [IW-1:0]      r_part  [NOTES];
    logic               r_pset  [NOTES];
    logic [PW-1:0]      r_next  [NOTES];
    logic [IW-1:0]      r_stack [NOTES];
    logic [PW-1:0]      r_depth;
    logic [GW-1:0]      r_guard;
    // Ranking sweep counters: side, self, other, compared.
    logic               r_side;
    logic [IW-1:0]      r_i, r_j, r_k;
    logic [IW-1:0]      r_cnt;
    logic [OW-1:0]      r_out;
    logic [OW-1:0]      r_mdata;
    logic               r_mvalid;

    // Shared distance unit: place of j in i's list = count of k that beat j.
    logic [6:0] w_self, w_oj, w_ok;
    logic [2:0] w_dj, w_dk;
    logic       w_beats;
    always_comb begin
        w_self = r_side ? r_held[r_i] : r_fresh[r_i];
        w_oj   = r_side ? r_fresh[r_j] : r_held[r_j];
        w_ok   = r_side ? r_fresh[r_k] : r_held[r_k];
        w_dj   = cvl_pkg::pc_abs(cvl_pkg::pc_of(w_self), cvl_pkg::pc_of(w_oj));
        w_dk   = cvl_pkg::pc_abs(cvl_pkg::pc_of(w_self), cvl_pkg::pc_of(w_ok));
        w_beats = (w_dk < w_dj) || (w_dk == w_dj && r_k < r_j);
    end

    // Proposal step.
    logic [IW-1:0] w_s, w_w, w_np;
    logic          w_live;
    always_comb begin
        w_s    = r_stack[IW'(r_depth - PW'(1))];
        w_live = r_next[w_s] < PW'(NOTES);
        w_w    = r_pref[w_s][r_next[w_s][IW-1:0]];
        w_np   = r_part[w_w];
    end

    // Voice update for one held note.
    logic [6:0]        w_h, w_f, w_led;
    logic signed [8:0] w_sum;
    always_comb begin
        w_h   = r_held[r_i];
        w_f   = r_fresh[r_part[r_i]];
        w_sum = 9'(signed'({2'b0, w_h}));
        if (r_pset[r_i])
            w_sum = w_sum + 9'(cvl_pkg::pc_step(cvl_pkg::pc_of(w_h), cvl_pkg::pc_of(w_f)));
        if (w_sum < 0) w_led = 7'd0;
        else if (w_sum > 9'sd127) w_led = 7'd127;
        else w_led = w_sum[6:0];
    end

    logic w_last_i, w_last_j, w_last_k;
    assign w_last_i = r_i == IW'(NOTES-1);
    assign w_last_j = r_j == IW'(NOTES-1);
    assign w_last_k = r_k == IW'(NOTES-1);

    // The finished result moves on once the output register is free.
    logic w_load;
    assign w_load = (r_state == S_OUT) && (!r_mvalid || m_axis_tready);

    assign s_axis_tready = r_state == S_IDLE;
    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_have   <= 1'b0;
            r_mvalid <= 1'b0;
            for (int n = 0; n < NOTES; n++) r_held[n] <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    logic [OW-1:0] o;
                    o = '0;
                    for (int n = 0; n < NOTES; n++)
                        o[n*7 +: 7] = r_have ? r_held[n] : 7'd0;
                    o[NOTES*7] = r_have;
                    if (s_axis_tvalid) begin
                        r_out <= o;
                        for (int n = 0; n < NOTES; n++)
                            r_fresh[n] <= s_axis_tdata[n*7 +: 7];
                        r_on   <= s_axis_tuser;
                        r_side <= 1'b0;
                        r_i <= '0; r_j <= '0; r_k <= '0; r_cnt <= '0;
                        if (!s_axis_tuser) r_state <= S_OUT;
                        else if (r_have) r_state <= S_RANK;
                        else r_state <= S_LEAD;
                    end
                end
                S_RANK: begin
                    logic [IW-1:0] c;
                    c = r_cnt + IW'(w_beats && r_k != r_j);
                    if (w_last_k) begin
                        if (r_side) r_arank[r_i][r_j] <= c;
                        else        r_pref[r_i][c]    <= r_j;
                        r_cnt <= '0;
                        r_k   <= '0;
                        if (w_last_j) begin
                            r_j <= '0;
                            if (w_last_i) begin
                                r_i <= '0;
                                if (r_side) r_state <= S_INIT;
                                r_side <= 1'b1;
                            end else r_i <= r_i + IW'(1);
                        end else r_j <= r_j + IW'(1);
                    end else begin
                        r_cnt <= c;
                        r_k   <= r_k + IW'(1);
                    end
                end
                S_INIT: begin
                    for (int n = 0; n < NOTES; n++) begin
                        r_pset[n]  <= 1'b0;
                        r_part[n]  <= '0;
                        r_next[n]  <= '0;
                        r_stack[n] <= IW'(n);
                    end
                    r_depth <= PW'(NOTES);
                    r_guard <= '0;
                    r_state <= S_PROP;
                end
                S_PROP: begin
                    if (r_depth == '0 || r_guard == GW'(NOTES*NOTES + NOTES)) begin
                        r_i <= '0;
                        r_state <= S_LEAD;
                    end else begin
                        r_guard <= r_guard + GW'(1);
                        if (!w_live) r_depth <= r_depth - PW'(1);
                        else begin
                            r_next[w_s] <= r_next[w_s] + PW'(1);
                            if (!r_pset[w_w]) begin
                                r_pset[w_w] <= 1'b1;
                                r_part[w_w] <= w_s;
                                r_depth <= r_depth - PW'(1);
                            end else if (r_arank[w_w][w_np] > r_arank[w_w][w_s]) begin
                                r_stack[IW'(r_depth - PW'(1))] <= w_np;
                                r_part[w_w] <= w_s;
                            end
                        end
                    end
                end
                S_LEAD: begin
                    logic [6:0]    v;
                    logic [OW-1:0] o;
                    v = r_have ? w_led : r_fresh[r_i];
                    o = r_out;
                    o[NOTES*7 + 1 + 7*r_i +: 7] = v;
                    if (w_last_i) o[NOTES*14 + 1] = 1'b1;
                    r_out <= o;
                    r_held[r_i] <= v;
                    if (w_last_i) begin
                        r_have  <= 1'b1;
                        r_state <= S_OUT;
                    end else r_i <= r_i + IW'(1);
                end
                S_OUT: begin
                    if (w_load) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase

            if (w_load) begin
                r_mdata  <= r_out;
                r_mvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_mvalid <= 1'b0;
            end
        end
    end

    // A finished result carries led_valid equal to the accepted note_on flag.
    a_led_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |-> r_out[NOTES*14 + 1] == r_on)
        else $error("led_valid does not follow note_on");
    // The proposal stack never grows past the voice count.
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PROP |-> r_depth <= PW'(NOTES))
        else $error("free stack overflow");
    // After a note-on result is finished, a chord is held.
    a_have: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_on) |-> r_have)
        else $error("note-on result without held chord");

endmodule
